/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* hdl/mbp_pkg.sv */
// ---------------------------------------------------------------------------
// mbp_pkg
// shared constants, codes and types of the msb-first bit packer
// ---------------------------------------------------------------------------
package mbp_pkg;

    localparam int MAX_BYTES = 64;
    localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int UB_W      = $clog2(MAX_BYTES + 1);
    localparam int CUR_W     = UB_W + 3;
    localparam int SUM_W     = CUR_W + 2;

    localparam int OP_W      = 2;
    localparam int VAL_W     = 16;
    localparam int CNT_W     = 5;
    localparam int BL_W      = 10;
    localparam int BUF_W     = 7;
    localparam int MAX_CNT   = 16;
    localparam int WIN_W     = 24;

    localparam logic [BUF_W-1:0] BUF_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_REWIND = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clr;
        logic [UB_W-1:0]   clr_bytes;
    } mbp_ram_req_t;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] read_value;
        logic [BL_W-1:0]  bits_left;
    } mbp_res_t;

    // ones in the low cnt bits
    function automatic logic [VAL_W-1:0] low_mask(input logic [CNT_W-1:0] cnt);
        logic [31:0] m;
        m = (32'd1 << cnt) - 32'd1;
        return VAL_W'(m);
    endfunction

endpackage

/* hdl/mbp_byte_ram.sv */
// ---------------------------------------------------------------------------
// mbp_byte_ram
// byte store: one read and one write port, registered read, per-entry
// valid flags so that reset and clear each drop all their flags in the same cycle
// ---------------------------------------------------------------------------
module mbp_byte_ram import mbp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  mbp_ram_req_t ram_req,
    output logic [7:0]   rd_data
);

    logic [7:0]           mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [RAM_DEPTH-1:0] clr_mask;
    logic [7:0]           rd_q_reg;
    logic                 vld_q_reg;

    always_comb begin
        for (int i = 0; i < RAM_DEPTH; i++) begin
            clr_mask[i] = UB_W'(i) < ram_req.clr_bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
        if (ram_req.rd_en) begin
            rd_q_reg <= mem[ram_req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (ram_req.clr) begin
                valid_reg <= valid_reg & ~clr_mask;
            end
            if (ram_req.wr_en) begin
                valid_reg[ram_req.wr_addr] <= 1'b1;
            end
            if (ram_req.rd_en) begin
                vld_q_reg <= valid_reg[ram_req.rd_addr];
            end
        end
    end

    // entries never written since reset, or since a clear that covered them, read as zero
    assign rd_data = vld_q_reg ? rd_q_reg : 8'h00;

endmodule

/* hdl/mbp_seq.sv */
// ---------------------------------------------------------------------------
// mbp_seq
// operation sequencer: bounds check, cursor, one byte read-modify-write
// per cycle (reads skip the write back) over the up to three bytes a word touches
// ---------------------------------------------------------------------------
module mbp_seq import mbp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_operation,
    input  logic [VAL_W-1:0] s_write_value,
    input  logic [CNT_W-1:0] s_bit_count,
    input  logic [UB_W-1:0]  used_bytes,
    input  logic             out_free,
    output mbp_ram_req_t     ram_req,
    input  logic [7:0]       ram_rd_data,
    output logic             res_load,
    output mbp_res_t         res
);

    state_t            state_reg, state_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [CUR_W-1:0]  total_bits;
    logic [1:0]        k_reg;
    logic              is_read_reg;
    logic              status_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [4:0]        bit_end_reg;
    logic [1:0]        nb_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [WIN_W-1:0]  wwin_reg;
    logic [WIN_W-1:0]  rwin_reg;

    op_t               op_in;
    logic              accept;
    logic              op_rw;
    logic              cnt_bad;
    logic              overrun;
    logic              item_ok;
    logic [SUM_W-1:0]  cur_sum;
    logic [5:0]        bit_end6;
    logic [1:0]        nb_new;
    logic [ADDR_W-1:0] base_new;
    logic [VAL_W-1:0]  wval_masked;
    logic [WIN_W-1:0]  wwin_new;
    logic [WIN_W-1:0]  rwin_step;
    logic [WIN_W-1:0]  wshift;
    logic [WIN_W-1:0]  rwin_fin;
    logic [WIN_W-1:0]  rshift;
    logic              last_step;

    // item decode
    always_comb begin
        op_in       = op_t'(s_operation);
        total_bits  = {used_bytes, 3'b000};
        accept      = s_valid && s_ready;
        op_rw       = (op_in == OP_WRITE) || (op_in == OP_READ);
        cnt_bad     = s_bit_count > CNT_W'(MAX_CNT);
        cur_sum     = SUM_W'(cursor_reg) + SUM_W'(s_bit_count);
        overrun     = cur_sum > SUM_W'(total_bits);
        item_ok     = op_rw && !cnt_bad && !overrun;
        bit_end6    = 6'(cursor_reg[2:0]) + 6'(s_bit_count);
        nb_new      = item_ok ? 2'((bit_end6 + 6'd7) >> 3) : 2'd0;
        base_new    = ADDR_W'(cursor_reg >> 3);
        wval_masked = s_write_value & low_mask(s_bit_count);
        // value placed so its last bit lands just before the end position
        wwin_new    = WIN_W'(wval_masked) << (6'(WIN_W) - bit_end6);
    end

    // byte step datapath
    always_comb begin
        rwin_step = rwin_reg | (WIN_W'({ram_rd_data, 16'h0000}) >> {k_reg, 3'b000});
        wshift    = wwin_reg << {k_reg, 3'b000};
        last_step = (k_reg + 2'd1) == nb_reg;
        rwin_fin  = (state_reg == S_RUN) ? rwin_step : rwin_reg;
        rshift    = rwin_fin >> (5'(WIN_W) - bit_end_reg);
    end

    always_comb begin
        cursor_next = cursor_reg;
        if (accept) begin
            case (op_in) inside
                OP_WRITE, OP_READ: begin
                    if (item_ok) begin
                        cursor_next = CUR_W'(cur_sum);
                    end
                end
                OP_REWIND, OP_CLEAR: begin
                    cursor_next = '0;
                end
                default: begin
                    cursor_next = cursor_reg;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (nb_new != 2'd0) ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (last_step) begin
                    state_next = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        ram_req  = '0;
        res_load = 1'b0;
        ram_req.clr_bytes = used_bytes;
        unique case (state_reg)
            S_IDLE: begin
                s_ready         = 1'b1;
                ram_req.rd_en   = accept;
                ram_req.rd_addr = base_new;
                ram_req.clr     = accept && (op_in == OP_CLEAR);
            end
            S_RUN: begin
                if (!is_read_reg) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = base_reg + ADDR_W'(k_reg);
                    ram_req.wr_data = ram_rd_data | wshift[WIN_W-1 -: 8];
                end
                // next byte read overlaps this byte's write back
                if (!last_step) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = base_reg + ADDR_W'(k_reg + 2'd1);
                end
                res_load = last_step && out_free;
            end
            S_DONE: begin
                res_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        res.status     = status_reg;
        res.read_value = (is_read_reg && !status_reg)
                         ? (VAL_W'(rshift) & low_mask(cnt_reg)) : '0;
        res.bits_left  = (cursor_reg > total_bits) ? '0 : BL_W'(total_bits - cursor_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            if (accept) begin
                k_reg <= '0;
            end else if (state_reg == S_RUN) begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            is_read_reg <= op_in == OP_READ;
            status_reg  <= op_rw && !item_ok;
            cnt_reg     <= s_bit_count;
            bit_end_reg <= 5'(bit_end6);
            nb_reg      <= nb_new;
            base_reg    <= base_new;
            wwin_reg    <= wwin_new;
            rwin_reg    <= '0;
        end else if (state_reg == S_RUN) begin
            rwin_reg <= rwin_step;
        end
    end

endmodule

/* hdl/msb_first_bit_packer_unit.sv */
// ---------------------------------------------------------------------------
// msb_first_bit_packer_unit
// byte store with a bit cursor: msb-first writes and reads of 0 to 16 bits,
// rewind and clear, one result word per input word
// ---------------------------------------------------------------------------
//  channel  ports                                   direction
//  s_       valid/ready, operation, value, count    word in
//  m_       valid/ready, status, read_value, left   word out
//  cfg_     wr_en, wr_data (buffer bytes)           register write
//
//  a word touches 0 to 3 store bytes, one byte read-modify-write per cycle
//  through the store's ports
//  reset clears the store valid flags at once, no sweep; clear likewise
//  a full output register holds the finished word; the next word is still
//  taken while the result waits to be collected
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_first_bit_packer_unit import mbp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_operation,
    input  logic [VAL_W-1:0] s_write_value,
    input  logic [CNT_W-1:0] s_bit_count,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_status,
    output logic [VAL_W-1:0] m_read_value,
    output logic [BL_W-1:0]  m_bits_left,
    input  logic             cfg_wr_en,
    input  logic [BUF_W-1:0] cfg_wr_data
);

    logic [BUF_W-1:0] buffer_bytes_reg;
    logic [UB_W-1:0]  used_bytes;
    logic             m_valid_reg;
    mbp_res_t         m_res_reg;
    logic             out_free;
    logic             res_load;
    mbp_res_t         res;
    mbp_ram_req_t     ram_req;
    logic [7:0]       ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_bytes_reg <= BUF_RESET;
        end else if (cfg_wr_en) begin
            buffer_bytes_reg <= cfg_wr_data;
        end
    end

    // oversized setting acts as the full store
    always_comb begin
        if (32'(buffer_bytes_reg) > MAX_BYTES) begin
            used_bytes = UB_W'(MAX_BYTES);
        end else begin
            used_bytes = UB_W'(buffer_bytes_reg);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    mbp_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_write_value (s_write_value),
        .s_bit_count   (s_bit_count),
        .used_bytes    (used_bytes),
        .out_free      (out_free),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data),
        .res_load      (res_load),
        .res           (res)
    );

    mbp_byte_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ram_req (ram_req),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_res_reg.status;
    assign m_read_value = m_res_reg.read_value;
    assign m_bits_left  = m_res_reg.bits_left;

    `ASSERT_PROP(a_load_free, aclk, aresetn, res_load |-> out_free, "result loaded over an uncollected word")
    `ASSERT_PROP(a_one_word, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "second word taken while one is in flight")
    `ASSERT_NEVER(a_wr_idle, aclk, aresetn, ram_req.wr_en && s_ready, "store written while idle")

endmodule

/* dv/tb_msb_first_bit_packer_unit.sv */
// ---------------------------------------------------------------------------
// tb_msb_first_bit_packer_unit
// self-checking bench for the msb-first bit packer: a scoreboard keeps its
// own copy of the byte store, cursor and buffer size, predicts the status,
// read value and bits left of every accepted word and checks the result
// words in order; directed corner cases, then random traffic under varying
// buffer sizes and handshake pressure
// ---------------------------------------------------------------------------
module tb_msb_first_bit_packer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mbp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_WORDS   = 110;

    class packer_scoreboard;
        logic [BUF_W-1:0] buffer_bytes;
        int               cursor;
        logic [7:0]       store [MAX_BYTES];
        mbp_res_t         expected_results [$];
        int               err_count;
        int               result_count;

        function new();
            buffer_bytes = BUF_RESET;
            cursor       = 0;
            foreach (store[i]) store[i] = '0;
            err_count    = 0;
            result_count = 0;
        endfunction

        task report_mismatch(string msg);
            err_count++;
            $display("[%0t] mismatch on result %0d: %s", $time, result_count, msg);
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        function void set_buffer(logic [BUF_W-1:0] nbytes);
            buffer_bytes = nbytes;
        endfunction

        function int used_bytes();
            return (buffer_bytes > MAX_BYTES) ? MAX_BYTES : int'(buffer_bytes);
        endfunction

        // apply one word to the private store and note its result
        function void note_word(op_t op, logic [VAL_W-1:0] val, logic [CNT_W-1:0] cnt);
            mbp_res_t res;
            int       total;
            int       n;
            int       pos;
            int       idx;
            int       sh;
            int       i;
            res   = '0;
            total = used_bytes() * 8;
            n     = int'(cnt);
            case (op) inside
                OP_WRITE, OP_READ: begin
                    if (n > MAX_CNT || cursor + n > total) begin
                        res.status = 1'b1;
                    end else begin
                        for (i = 0; i < n; i++) begin
                            pos = cursor + i;
                            idx = (pos >> 3) % MAX_BYTES;
                            sh  = 7 - (pos & 7);
                            if (op == OP_WRITE) begin
                                store[idx][sh] = store[idx][sh] | val[n - 1 - i];
                            end else begin
                                res.read_value = {res.read_value[VAL_W-2:0], store[idx][sh]};
                            end
                        end
                        cursor = cursor + n;
                    end
                end
                OP_REWIND: begin
                    cursor = 0;
                end
                default: begin
                    cursor = 0;
                    // only the bytes in use are zeroed
                    for (i = 0; i < used_bytes(); i++) store[i] = '0;
                end
            endcase
            res.bits_left = BL_W'((cursor > total) ? 0 : total - cursor);
            expected_results.push_back(res);
        endfunction

        task check_word(logic status, logic [VAL_W-1:0] rv, logic [BL_W-1:0] bl);
            mbp_res_t want;
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result word with none expected");
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                report_mismatch($sformatf("status %b, expected %b", status, want.status));
            end
            if (rv !== want.read_value) begin
                report_mismatch($sformatf("read_value %h, expected %h", rv, want.read_value));
            end
            if (bl !== want.bits_left) begin
                report_mismatch($sformatf("bits_left %0d, expected %0d", bl, want.bits_left));
            end
        endtask
    endclass

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [OP_W-1:0]  s_operation   = '0;
    logic [VAL_W-1:0] s_write_value = '0;
    logic [CNT_W-1:0] s_bit_count   = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic             m_status;
    logic [VAL_W-1:0] m_read_value;
    logic [BL_W-1:0]  m_bits_left;
    logic             cfg_wr_en     = 1'b0;
    logic [BUF_W-1:0] cfg_wr_data   = '0;

    packer_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    msb_first_bit_packer_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_write_value (s_write_value),
        .s_bit_count   (s_bit_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_bits_left   (m_bits_left),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_msb_first_bit_packer_unit: done, errors");
            $finish;
        end
    end

    // result side: check on handshake, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_status, m_read_value, m_bits_left);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input op_t op, input logic [VAL_W-1:0] val,
                             input logic [CNT_W-1:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_write_value <= val;
        s_bit_count   <= cnt;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_word(op, val, cnt);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_buffer_bytes(input logic [BUF_W-1:0] nbytes);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= nbytes;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_buffer(nbytes);
    endtask

    function automatic logic [BUF_W-1:0] random_buffer_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return BUF_W'($urandom_range(1, MAX_BYTES));
        if (pick < 80) return BUF_W'($urandom_range(0, 3));
        return BUF_W'($urandom_range(MAX_BYTES + 1, 127));
    endfunction

    // mostly well-formed writes and reads so the cursor runs into the end
    task automatic send_random_word();
        int               pick;
        op_t              op;
        logic [CNT_W-1:0] cnt;
        pick = $urandom_range(99);
        if (pick < 52) op = OP_WRITE;
        else if (pick < 91) op = OP_READ;
        else if (pick < 97) op = OP_REWIND;
        else op = OP_CLEAR;
        if ($urandom_range(99) < 10) cnt = CNT_W'($urandom_range(MAX_CNT + 1, 31));
        else cnt = CNT_W'($urandom_range(0, MAX_CNT));
        send_word(op, VAL_W'($urandom()), cnt);
    endtask

    initial begin
        int phase;
        int seg;
        int k;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 29;
        recv_idle_pct = 86;

        // directed: widths, byte crossings, count errors, zero counts
        send_word(OP_WRITE, 16'hFFFF, 5'd3);
        send_word(OP_WRITE, 16'hA5C3, 5'd16);   // spans three bytes
        send_word(OP_WRITE, 16'h1234, 5'd13);
        send_word(OP_WRITE, 16'hFFFF, 5'd17);
        send_word(OP_REWIND, 16'h0000, 5'd0);
        send_word(OP_READ, 16'h0000, 5'd3);
        send_word(OP_READ, 16'hFFFF, 5'd0);
        send_word(OP_READ, 16'h0000, 5'd16);
        send_word(OP_READ, 16'h0000, 5'd13);
        send_word(OP_READ, 16'h0000, 5'd31);
        send_word(OP_CLEAR, 16'hFFFF, 5'd31);
        send_word(OP_READ, 16'h0000, 5'd16);

        // overrun at a two byte buffer, zero count right at the end
        write_buffer_bytes(7'd2);
        send_word(OP_WRITE, 16'hFFFF, 5'd16);
        send_word(OP_WRITE, 16'hFFFF, 5'd0);
        send_word(OP_REWIND, 16'h0000, 5'd0);
        send_word(OP_WRITE, 16'h8001, 5'd16);

        // cursor left beyond the end: nothing left, zero counts fail
        write_buffer_bytes(7'd1);
        send_word(OP_WRITE, 16'h0000, 5'd0);
        send_word(OP_READ, 16'h0000, 5'd0);

        write_buffer_bytes(7'd0);
        send_word(OP_REWIND, 16'h0000, 5'd0);
        send_word(OP_READ, 16'h0000, 5'd0);
        send_word(OP_WRITE, 16'hFFFF, 5'd1);

        // oversized buffer acts as the full store
        write_buffer_bytes(7'd127);
        send_word(OP_READ, 16'h0000, 5'd16);
        send_word(OP_CLEAR, 16'h0000, 5'd0);

        // clear with a small buffer keeps the bytes above it
        write_buffer_bytes(7'd64);
        send_word(OP_WRITE, 16'hBEEF, 5'd16);
        send_word(OP_WRITE, 16'hCAFE, 5'd16);
        write_buffer_bytes(7'd1);
        send_word(OP_CLEAR, 16'h0000, 5'd0);
        write_buffer_bytes(7'd64);
        send_word(OP_READ, 16'h0000, 5'd16);
        send_word(OP_READ, 16'h0000, 5'd16);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < 5; seg++) begin
                write_buffer_bytes(random_buffer_size());
                for (k = 0; k < SEG_WORDS; k++) begin
                    send_random_word();
                    // hold off until the block has emptied once per phase
                    if (seg == 2 && k == SEG_WORDS / 2) drain_results();
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.err_count == 0 && sb.pending() == 0) begin
            $display("tb_msb_first_bit_packer_unit: done, clean");
        end else begin
            $display("tb_msb_first_bit_packer_unit: done, errors");
        end
        $finish;
    end

endmodule
